@@ hdl/cisss_pkg.sv @@
// ----------------------------------------------------------------------------
// cisss_pkg
// Shared types, constants and helpers for the case-insensitive substring
// search core.
// ----------------------------------------------------------------------------
package cisss_pkg;

    localparam int NEEDLE_MAX   = 16;
    localparam int LEN_BITS     = 5;
    localparam int AGE_BITS     = 4;
    localparam int START_BITS   = 20;
    localparam int CFG_BITS     = 64;
    localparam int INDEX_BITS   = 2;

    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'd32;

    localparam logic [INDEX_BITS-1:0] REG_NEEDLE_LOW  = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_NEEDLE_HIGH = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_NEEDLE_LEN  = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_of_text;
    } text_word_t;

    typedef struct packed {
        logic                  match_found;
        logic [START_BITS-1:0] match_start;
    } result_word_t;

    function automatic logic [7:0] fold_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= LOWER_A && b <= LOWER_Z)
        begin
            r = b - CASE_DELTA;
        end
        return r;
    endfunction

endpackage

@@ hdl/cisss_input_stage.sv @@
// ----------------------------------------------------------------------------
// cisss_input_stage
// Input register: holds one text word for the matcher and takes the next
// word whenever the held one moves on.
// ----------------------------------------------------------------------------
module cisss_input_stage
    import cisss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  text_word_t in_word,
    input  logic       advance,
    output logic       held_valid,
    output text_word_t held_word
);

    logic       valid_reg;
    logic       valid_next;
    text_word_t word_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

@@ hdl/cisss_matcher.sv @@
// ----------------------------------------------------------------------------
// cisss_matcher
// Byte window, position counter and first-match latch; compares the newest
// bytes with the folded needle in parallel and forms the result word.
// ----------------------------------------------------------------------------
module cisss_matcher
    import cisss_pkg::*;
#(
    parameter int POSITION_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  text_word_t            held_word,
    input  logic [CFG_BITS-1:0]   needle_low,
    input  logic [CFG_BITS-1:0]   needle_high,
    input  logic [LEN_BITS-1:0]   needle_len,
    output result_word_t          result
);

    logic [7:0]               window_reg [NEEDLE_MAX];
    logic [7:0]               window_next [NEEDLE_MAX];
    logic [POSITION_BITS-1:0] count_reg;
    logic [POSITION_BITS-1:0] count_next;
    logic                     seen_reg;
    logic                     seen_next;
    logic [POSITION_BITS-1:0] start_reg;
    logic [POSITION_BITS-1:0] start_next;
    logic [POSITION_BITS-1:0] found_start;
    logic [LEN_BITS-1:0]      len;
    logic [NEEDLE_MAX-1:0]    lane_ok;
    logic                     hit;
    logic [31:0]              start_wide;
    logic [2*CFG_BITS-1:0]    needle_all;

    assign needle_all = {needle_high, needle_low};
    assign len = (needle_len > LEN_BITS'(NEEDLE_MAX)) ? LEN_BITS'(NEEDLE_MAX) : needle_len;

    always_comb
    begin
        window_next[0] = held_word.text_byte;
        for (int k = 1; k < NEEDLE_MAX; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    assign count_next = (&count_reg) ? count_reg : count_reg + POSITION_BITS'(1);

    always_comb
    begin
        logic [LEN_BITS-1:0] age;
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            age = len - LEN_BITS'(i) - LEN_BITS'(1);
            if (LEN_BITS'(i) >= len)
            begin
                lane_ok[i] = 1'b1;
            end
            else
            begin
                lane_ok[i] = fold_upper(window_next[age[AGE_BITS-1:0]])
                             == fold_upper(needle_all[8*i +: 8]);
            end
        end
    end

    assign hit         = (&lane_ok) && (count_next >= POSITION_BITS'(len));
    assign found_start = count_next - POSITION_BITS'(len);

    always_comb
    begin
        seen_next  = seen_reg;
        start_next = start_reg;
        if (!seen_reg)
        begin
            if (len == '0)
            begin
                seen_next  = 1'b1;
                start_next = '0;
            end
            else if (hit)
            begin
                seen_next  = 1'b1;
                start_next = found_start;
            end
        end
    end

    assign start_wide         = 32'(start_next);
    assign result.match_found = seen_next;
    assign result.match_start = seen_next ? start_wide[START_BITS-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NEEDLE_MAX; k++)
            begin
                window_reg[k] <= '0;
            end
            count_reg <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (advance)
        begin
            if (held_word.last_of_text)
            begin
                for (int k = 0; k < NEEDLE_MAX; k++)
                begin
                    window_reg[k] <= '0;
                end
                count_reg <= '0;
                seen_reg  <= 1'b0;
                start_reg <= '0;
            end
            else
            begin
                for (int k = 0; k < NEEDLE_MAX; k++)
                begin
                    window_reg[k] <= window_next[k];
                end
                count_reg <= count_next;
                seen_reg  <= seen_next;
                start_reg <= start_next;
            end
        end
    end

endmodule

@@ hdl/case_insensitive_substring_search_core.sv @@
// ----------------------------------------------------------------------------
// case_insensitive_substring_search_core
// Streams text bytes against a needle of up to 16 bytes, folding ASCII
// letters to upper case, and reports the first match of each text.
// ----------------------------------------------------------------------------
// The core takes one text word per clock cycle unless the input is stalled.
// Each word is held in an input register; while it is held, the 16-byte
// window is compared with the needle in parallel and, on the word marked
// last of text, the result is loaded from the matcher into the output
// register. A last word waits in the input register while the previous
// result has not been taken, which stalls the input.
// Write the needle registers only while no text is in flight. Position
// counting saturates at 2^POSITION_BITS - 1.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search_core
    import cisss_pkg::*;
#(
    parameter int POSITION_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [INDEX_BITS-1:0] wr_index,
    input  logic [CFG_BITS-1:0]   wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  text_word_t            in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_word_t          out_word
);

    logic [CFG_BITS-1:0] needle_low_reg;
    logic [CFG_BITS-1:0] needle_high_reg;
    logic [LEN_BITS-1:0] needle_len_reg;
    logic                held_valid;
    text_word_t          held_word;
    logic                advance;
    result_word_t        result;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_word_t        out_word_reg;
    logic                load_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            needle_len_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_NEEDLE_LOW:  needle_low_reg  <= wr_data;
                REG_NEEDLE_HIGH: needle_high_reg <= wr_data;
                REG_NEEDLE_LEN:  needle_len_reg  <= wr_data[LEN_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // advance when the result slot is free or the word yields no result
    assign advance = held_valid &&
                     (!held_word.last_of_text || !out_valid_reg || out_ready);
    assign load_result = advance && held_word.last_of_text;

    cisss_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .advance    (advance),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    cisss_matcher #(
        .POSITION_BITS (POSITION_BITS)
    ) u_matcher (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .held_word   (held_word),
        .needle_low  (needle_low_reg),
        .needle_high (needle_high_reg),
        .needle_len  (needle_len_reg),
        .result      (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
